[hw/rtl/csp_pkg.sv]
package csp_pkg;

    // profile geometry
    localparam int SEGMENTS = 11;
    localparam int HALF     = (SEGMENTS + 1) / 2;
    localparam int BASE_LEN = 6;

    localparam int SEG_W   = $clog2(SEGMENTS + 1);
    localparam int HALF_AW = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int BASE_AW = $clog2(BASE_LEN);

    // data widths
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 16;
    localparam int DUR_W   = 16;
    localparam int PER_W   = 29;
    localparam int CNT_W   = 32;
    localparam int BSTEP_W = 7;
    localparam int BPER_W  = 13;

    // period divider
    localparam int NUM_W  = 32;
    localparam int DEN_W  = 19;
    localparam int ITER_W = $clog2(NUM_W);

    localparam int STEP_DIVISOR = 800;

    // count * base / 800 as a multiply by ceil(2^33 / 800), exact for 23-bit products
    localparam int STEP_PROD_W      = STEP_W + BSTEP_W;
    localparam int STEP_RECIP_W     = 24;
    localparam int STEP_RECIP_SHIFT = 33;
    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = 24'd10737419;

    function automatic logic [BSTEP_W-1:0] base_steps(input logic [BASE_AW-1:0] i);
        logic [BSTEP_W-1:0] v;
        case (i)
            3'd0:    v = 7'd16;
            3'd1:    v = 7'd47;
            3'd2:    v = 7'd75;
            3'd3:    v = 7'd96;
            3'd4:    v = 7'd109;
            default: v = 7'd114;
        endcase
        return v;
    endfunction

    function automatic logic [BPER_W-1:0] base_period(input logic [BASE_AW-1:0] i);
        logic [BPER_W-1:0] v;
        case (i)
            3'd0:    v = 13'd5682;
            3'd1:    v = 13'd1934;
            3'd2:    v = 13'd1212;
            3'd3:    v = 13'd947;
            3'd4:    v = 13'd834;
            default: v = 13'd797;
        endcase
        return v;
    endfunction

    // base-table row for a half-table entry; later entries reuse its last row
    function automatic logic [BASE_AW-1:0] base_slot(input logic [HALF_AW-1:0] i);
        logic [BASE_AW-1:0] v;
        if (int'(i) < BASE_LEN)
            v = BASE_AW'(i);
        else
            v = BASE_AW'(BASE_LEN - 1);
        return v;
    endfunction

    // mirror a segment number onto the half table
    function automatic logic [HALF_AW-1:0] half_slot(input logic [SEG_W-1:0] ix);
        logic [HALF_AW-1:0] v;
        if (ix < SEG_W'(HALF))
            v = HALF_AW'(ix);
        else if (ix < SEG_W'(SEGMENTS))
            v = HALF_AW'(SEG_W'(SEGMENTS - 1) - ix);
        else
            v = '0;
        return v;
    endfunction

endpackage

[hw/rtl/csp_if.sv]
interface csp_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] time_us;
    logic [31:0] time_ms;

    modport source (output valid, output command, output time_us, output time_ms,
                    input ready);
    modport sink   (input valid, input command, input time_us, input time_ms,
                    output ready);
endinterface

interface csp_out_if;
    logic        valid;
    logic        ready;
    logic        step_pulse;
    logic        driver_enable;
    logic        direction_level;
    logic [1:0]  phase;
    logic [3:0]  segment_number;
    logic [31:0] clockwise_total;
    logic [31:0] counter_clockwise_total;

    modport source (output valid, output step_pulse, output driver_enable,
                    output direction_level, output phase, output segment_number,
                    output clockwise_total, output counter_clockwise_total,
                    input ready);
    modport sink   (input valid, input step_pulse, input driver_enable,
                    input direction_level, input phase, input segment_number,
                    input clockwise_total, input counter_clockwise_total,
                    output ready);
endinterface

[hw/rtl/csp_div.sv]
module csp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [csp_pkg::NUM_W-1:0]   dividend,
    input  logic [csp_pkg::DEN_W-1:0]   divisor,
    output logic                        done,
    output logic [csp_pkg::NUM_W-1:0]   quotient
);
    import csp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;

    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W:0]    trial_sub;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
        else if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/cosine_step_profile_generator.sv]
// channel  | role | word
// ---------+------+-------------------------------------------------------------
// cmd_ch   | in   | command, time_us, time_ms
// res_ch   | out  | step_pulse, driver_enable, direction_level, phase,
//          |      | segment_number, clockwise_total, counter_clockwise_total
// cfg      | in   | cfg_we, cfg_index, cfg_data (write only)
//
// An update word goes through step table read, step decision, period table
// read, result register. An arm word fills the 6 half-table entries: step
// product, step sum (not for the last), period on the bit-serial divider.
// One word is in work at a time; the next is taken while the result still waits
// in res_ch, and a second finished word holds the input off until res_ch drains.
// Reset clears the control state; the profile tables hold nothing until armed.
module cosine_step_profile_generator (
    input  logic        clk,
    input  logic        rst_n,
    csp_in_if.sink      cmd_ch,
    csp_out_if.source   res_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import csp_pkg::*;

    localparam logic [2:0] CFG_START    = 3'd0;
    localparam logic [2:0] CFG_DIR      = 3'd1;
    localparam logic [2:0] CFG_COUNT    = 3'd2;
    localparam logic [2:0] CFG_DURATION = 3'd3;
    localparam logic [2:0] CFG_KEEP     = 3'd4;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SCHED  = 2'd1;
    localparam logic [1:0] PH_ACTIVE = 2'd2;
    localparam logic [1:0] PH_FIN    = 2'd3;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPD_A  = 3'd1;
    localparam logic [2:0] S_UPD_B  = 3'd2;
    localparam logic [2:0] S_ARM_S  = 3'd3;
    localparam logic [2:0] S_ARM_SW = 3'd4;
    localparam logic [2:0] S_ARM_P  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // configuration
    logic [TIME_W-1:0] start_time_reg;
    logic              move_dir_reg;
    logic [STEP_W-1:0] count_reg;
    logic [DUR_W-1:0]  duration_reg;
    logic              keep_reg;

    // control and scalar state
    logic [2:0]        state_reg;
    logic [1:0]        phase_reg;
    logic [SEG_W-1:0]  seg_idx_reg;
    logic [STEP_W-1:0] sis_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [PER_W-1:0]  period_reg;
    logic [CNT_W-1:0]  cw_reg;
    logic [CNT_W-1:0]  ccw_reg;
    logic              enable_reg;
    logic              dir_reg;
    logic              pulse_reg;
    logic              load_per_reg;
    logic [HALF_AW-1:0] arm_i_reg;
    logic [STEP_W-1:0] sum_reg;

    logic [TIME_W-1:0] t_us_reg;
    logic [TIME_W-1:0] t_ms_reg;

    // profile tables
    logic [STEP_W-1:0] steps_mem [HALF];
    logic [PER_W-1:0]  per_mem   [HALF];
    logic [STEP_W-1:0] steps_rd_reg;
    logic [PER_W-1:0]  per_rd_reg;
    logic [HALF_AW-1:0] steps_raddr;
    logic [HALF_AW-1:0] per_raddr;
    logic              steps_we;
    logic [STEP_W-1:0] steps_wdata;
    logic              per_we;

    // output register
    logic              out_valid_reg;
    logic              out_pulse_reg;
    logic              out_enable_reg;
    logic              out_dir_reg;
    logic [1:0]        out_phase_reg;
    logic [3:0]        out_seg_reg;
    logic [CNT_W-1:0]  out_cw_reg;
    logic [CNT_W-1:0]  out_ccw_reg;

    // divider
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_q;

    // update datapath
    logic              in_take;
    logic              out_free;
    logic [TIME_W-1:0] elapsed;
    logic              take_step;
    logic              active;
    logic              pulse;
    logic [STEP_W-1:0] sis_inc;
    logic              advance;
    logic [SEG_W-1:0]  seg_inc;
    logic              activate;
    logic              arm_last;

    logic [BASE_AW-1:0] bslot;
    logic [22:0]       step_prod;
    logic [28:0]       per_prod;
    logic              per_phase;
    logic [STEP_PROD_W-1:0] step_prod_reg;
    logic [STEP_PROD_W+STEP_RECIP_W-1:0] step_scaled;
    logic [STEP_W-1:0] step_q;

    assign in_take  = cmd_ch.valid && cmd_ch.ready;
    assign out_free = !out_valid_reg || res_ch.ready;
    assign cmd_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        elapsed   = t_us_reg - last_time_reg;
        take_step = (elapsed >= TIME_W'(period_reg));
        active    = (phase_reg == PH_ACTIVE);
        pulse     = take_step && active;
        sis_inc   = sis_reg + STEP_W'(pulse);
        advance   = active && (sis_inc >= steps_rd_reg);
        seg_inc   = seg_idx_reg + 1'b1;
        activate  = (phase_reg == PH_SCHED) && (t_ms_reg >= start_time_reg);
        arm_last  = (arm_i_reg == HALF_AW'(HALF - 1));
    end

    assign steps_raddr = half_slot(seg_idx_reg);
    assign per_raddr   = activate ? '0 : half_slot(seg_inc);

    // arm datapath: steps by reciprocal multiply or remainder, periods on the divider
    always_comb
    begin
        bslot       = base_slot(arm_i_reg);
        step_prod   = {7'd0, count_reg} * {16'd0, base_steps(bslot)};
        per_prod    = {13'd0, duration_reg} * {16'd0, base_period(bslot)};
        step_scaled = {{STEP_RECIP_W{1'b0}}, step_prod_reg}
                      * {{STEP_PROD_W{1'b0}}, STEP_RECIP};
        step_q      = STEP_W'(step_scaled[STEP_PROD_W+STEP_RECIP_W-1:STEP_RECIP_SHIFT]);
        per_phase   = ((state_reg == S_ARM_S) && arm_last) || (state_reg == S_ARM_SW);
        div_start   = per_phase;
        div_num     = {1'b0, per_prod, 2'b00};
        div_den     = {1'b0, count_reg, 2'b00} + {3'd0, count_reg};
        steps_we    = per_phase;
        steps_wdata = arm_last ? (count_reg - {sum_reg[STEP_W-2:0], 1'b0})
                               : step_q;
        per_we      = (state_reg == S_ARM_P) && div_done;
    end

    csp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (steps_we)
            steps_mem[arm_i_reg] <= steps_wdata;
        if (per_we)
            per_mem[arm_i_reg] <= div_q[PER_W-1:0];
        steps_rd_reg <= steps_mem[steps_raddr];
        per_rd_reg   <= per_mem[per_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ARM_S)
            step_prod_reg <= step_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            move_dir_reg   <= 1'b0;
            count_reg      <= 16'd800;
            duration_reg   <= 16'd1000;
            keep_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START:    start_time_reg <= cfg_data;
                CFG_DIR:      move_dir_reg   <= cfg_data[0];
                CFG_COUNT:    count_reg      <= cfg_data[STEP_W-1:0];
                CFG_DURATION: duration_reg   <= cfg_data[DUR_W-1:0];
                CFG_KEEP:     keep_reg       <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            t_us_reg <= cmd_ch.time_us;
            t_ms_reg <= cmd_ch.time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            seg_idx_reg   <= '0;
            sis_reg       <= '0;
            last_time_reg <= '0;
            period_reg    <= '0;
            cw_reg        <= '0;
            ccw_reg       <= '0;
            enable_reg    <= 1'b0;
            dir_reg       <= 1'b0;
            pulse_reg     <= 1'b0;
            load_per_reg  <= 1'b0;
            arm_i_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        pulse_reg <= 1'b0;
                        if (!cmd_ch.command)
                            state_reg <= S_UPD_A;
                        else if (count_reg == '0)
                            state_reg <= S_DONE;
                        else
                        begin
                            dir_reg   <= move_dir_reg;
                            phase_reg <= PH_SCHED;
                            arm_i_reg <= '0;
                            sum_reg   <= '0;
                            state_reg <= S_ARM_S;
                        end
                    end
                end

                S_UPD_A:
                begin
                    pulse_reg    <= pulse;
                    load_per_reg <= 1'b0;
                    if (take_step)
                        last_time_reg <= t_us_reg;
                    if (pulse && !dir_reg)
                        cw_reg <= cw_reg + 1'b1;
                    if (pulse && dir_reg)
                        ccw_reg <= ccw_reg + 1'b1;
                    if (active)
                    begin
                        if (advance)
                        begin
                            sis_reg     <= '0;
                            seg_idx_reg <= seg_inc;
                            if (seg_inc < SEG_W'(SEGMENTS))
                                load_per_reg <= 1'b1;
                            else
                            begin
                                enable_reg <= keep_reg;
                                phase_reg  <= PH_FIN;
                            end
                        end
                        else
                            sis_reg <= sis_inc;
                    end
                    else if (activate)
                    begin
                        enable_reg   <= 1'b1;
                        phase_reg    <= PH_ACTIVE;
                        cw_reg       <= '0;
                        ccw_reg      <= '0;
                        seg_idx_reg  <= '0;
                        sis_reg      <= '0;
                        load_per_reg <= 1'b1;
                    end
                    state_reg <= S_UPD_B;
                end

                S_UPD_B:
                begin
                    if (load_per_reg)
                        period_reg <= per_rd_reg;
                    state_reg <= S_DONE;
                end

                S_ARM_S:
                begin
                    // last entry closes the step total, no step scaling
                    state_reg <= arm_last ? S_ARM_P : S_ARM_SW;
                end

                S_ARM_SW:
                begin
                    sum_reg   <= sum_reg + step_q;
                    state_reg <= S_ARM_P;
                end

                S_ARM_P:
                begin
                    if (div_done)
                    begin
                        if (arm_i_reg == '0)
                            period_reg <= div_q[PER_W-1:0];
                        if (arm_last)
                            state_reg <= S_DONE;
                        else
                        begin
                            arm_i_reg <= arm_i_reg + 1'b1;
                            state_reg <= S_ARM_S;
                        end
                    end
                end

                S_DONE:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_pulse_reg  <= pulse_reg;
            out_enable_reg <= enable_reg;
            out_dir_reg    <= dir_reg;
            out_phase_reg  <= phase_reg;
            out_seg_reg    <= 4'(seg_idx_reg);
            out_cw_reg     <= cw_reg;
            out_ccw_reg    <= ccw_reg;
        end
    end

    assign res_ch.valid                   = out_valid_reg;
    assign res_ch.step_pulse              = out_pulse_reg;
    assign res_ch.driver_enable           = out_enable_reg;
    assign res_ch.direction_level         = out_dir_reg;
    assign res_ch.phase                   = out_phase_reg;
    assign res_ch.segment_number          = out_seg_reg;
    assign res_ch.clockwise_total         = out_cw_reg;
    assign res_ch.counter_clockwise_total = out_ccw_reg;

endmodule

[verif/cosine_step_profile_generator_tb.sv]
module cosine_step_profile_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csp_pkg::*;

    typedef enum bit [1:0] {
        PH_IDLE   = 2'd0,
        PH_SCHED  = 2'd1,
        PH_ACTIVE = 2'd2,
        PH_DONE   = 2'd3
    } run_phase_t;

    localparam bit CMD_UPDATE = 1'b0;
    localparam bit CMD_ARM    = 1'b1;

    localparam bit [2:0] REG_START = 3'd0;
    localparam bit [2:0] REG_DIR   = 3'd1;
    localparam bit [2:0] REG_STEPS = 3'd2;
    localparam bit [2:0] REG_DUR   = 3'd3;
    localparam bit [2:0] REG_KEEP  = 3'd4;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_WORDS = 550;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        bit              pulse;
        bit              enable;
        bit              dir;
        bit [1:0]        ph;
        bit [3:0]        seg;
        bit [CNT_W-1:0]  cw;
        bit [CNT_W-1:0]  ccw;
    } motion_word_t;

    localparam motion_word_t IDLE_WORD = '0;

    typedef enum bit {ROW_REG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        bit [2:0]      idx;
        bit [31:0]     data;
        bit            cmd;
        bit [31:0]     tus;
        bit [31:0]     tms;
        bit            typed;
        motion_word_t  want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    csp_in_if  cmd_ch ();
    csp_out_if res_ch ();

    cosine_step_profile_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    bit [TIME_W-1:0] start_ms_reg = '0;
    bit              dir_reg      = 1'b0;
    bit [STEP_W-1:0] count_reg    = 16'd800;
    bit [DUR_W-1:0]  dur_reg      = 16'd1000;
    bit              keep_reg     = 1'b0;

    // profile state
    bit [STEP_W-1:0] seg_steps_tab  [HALF];
    bit [PER_W-1:0]  seg_period_tab [HALF];
    run_phase_t      phase_q    = PH_IDLE;
    bit [SEG_W-1:0]  seg_ix     = '0;
    bit [STEP_W-1:0] seg_done   = '0;
    bit [TIME_W-1:0] last_us    = '0;
    bit [PER_W-1:0]  period_now = '0;
    bit [CNT_W-1:0]  cw_total   = '0;
    bit [CNT_W-1:0]  ccw_total  = '0;
    bit              enable_q   = 1'b0;
    bit              dir_q      = 1'b0;

    motion_word_t pending_words [$];
    motion_word_t head_word;
    int  words_sent    = 0;
    int  fail_count    = 0;
    bit  sender_calm   = 1'b0;
    bit  receiver_calm = 1'b0;
    bit  hold_request  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    function automatic bit [31:0] nominal_steps(int i);
        case ((i < BASE_LEN) ? i : BASE_LEN - 1)
            0:       return 32'd16;
            1:       return 32'd47;
            2:       return 32'd75;
            3:       return 32'd96;
            4:       return 32'd109;
            default: return 32'd114;
        endcase
    endfunction

    function automatic bit [31:0] nominal_period(int i);
        case ((i < BASE_LEN) ? i : BASE_LEN - 1)
            0:       return 32'd5682;
            1:       return 32'd1934;
            2:       return 32'd1212;
            3:       return 32'd947;
            4:       return 32'd834;
            default: return 32'd797;
        endcase
    endfunction

    function automatic int mirror_slot(int ix);
        return (ix < HALF) ? ix : SEGMENTS - 1 - ix;
    endfunction

    function automatic bit [PER_W-1:0] profile_period(int i);
        bit [31:0] num;
        bit [31:0] den;
        num = 32'(dur_reg) * nominal_period(i) * 32'd4;
        den = 32'd5 * 32'(count_reg);
        return PER_W'(num / den);
    endfunction

    task automatic advance_profile(input bit cmd, input bit [31:0] tus, input bit [31:0] tms,
                                   output motion_word_t w);
        bit [15:0] sum;
        bit [15:0] s;
        bit [31:0] elapsed;
        bit        pulse;
        pulse = 1'b0;
        if (cmd == CMD_ARM) begin
            if (count_reg != 0) begin
                sum = '0;
                dir_q = dir_reg;
                phase_q = PH_SCHED;
                for (int i = 0; i < HALF - 1; i++)
                begin
                    s = 16'((32'(count_reg) * nominal_steps(i)) / 32'(STEP_DIVISOR));
                    sum = sum + s;
                    seg_steps_tab[i] = s;
                    seg_period_tab[i] = profile_period(i);
                end
                // last half entry makes the move total come out exact
                seg_steps_tab[HALF-1] = 16'(32'(count_reg) - 32'd2 * 32'(sum));
                seg_period_tab[HALF-1] = profile_period(HALF - 1);
                period_now = seg_period_tab[0];
            end
        end else begin
            elapsed = tus - last_us;
            if (elapsed >= 32'(period_now)) begin
                if (phase_q == PH_ACTIVE) begin
                    pulse = 1'b1;
                    if (dir_q == 1'b0)
                        cw_total = cw_total + 1;
                    else
                        ccw_total = ccw_total + 1;
                    seg_done = seg_done + 1'b1;
                end
                last_us = tus;
            end
            if (phase_q == PH_ACTIVE) begin
                if (seg_done >= seg_steps_tab[mirror_slot(int'(seg_ix))]) begin
                    seg_done = '0;
                    seg_ix = seg_ix + 1'b1;
                    if (int'(seg_ix) < SEGMENTS)
                        period_now = seg_period_tab[mirror_slot(int'(seg_ix))];
                    else begin
                        enable_q = keep_reg;
                        phase_q = PH_DONE;
                    end
                end
            end else if (phase_q == PH_SCHED && tms >= start_ms_reg) begin
                enable_q = 1'b1;
                phase_q = PH_ACTIVE;
                cw_total = '0;
                ccw_total = '0;
                seg_ix = '0;
                seg_done = '0;
                period_now = seg_period_tab[0];
            end
        end
        w.pulse = pulse;
        w.enable = enable_q;
        w.dir = dir_q;
        w.ph = phase_q;
        w.seg = 4'(seg_ix);
        w.cw = cw_total;
        w.ccw = ccw_total;
    endtask

    function automatic int pause_length(bit calm);
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 14) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic offer_word(input bit cmd, input bit [31:0] tus, input bit [31:0] tms,
                              input bit typed, input motion_word_t want);
        motion_word_t w;
        int           n;
        @(negedge clk);
        cmd_ch.valid = 1'b1;
        cmd_ch.command = cmd;
        cmd_ch.time_us = tus;
        cmd_ch.time_ms = tms;
        do @(posedge clk); while (!cmd_ch.ready);
        advance_profile(cmd, tus, tms, w);
        pending_words.push_back(typed ? want : w);
        words_sent++;
        if ($urandom_range(0, 99) == 0)
            sender_calm = !sender_calm;
        n = pause_length(sender_calm);
        if (n > 0) begin
            @(negedge clk);
            cmd_ch.valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // drop valid and let every word in flight come back
    task automatic drain_block();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input bit [2:0] idx, input bit [31:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            REG_START: start_ms_reg = value;
            REG_DIR:   dir_reg = value[0];
            REG_STEPS: count_reg = value[15:0];
            REG_DUR:   dur_reg = value[15:0];
            REG_KEEP:  keep_reg = value[0];
            default:   ;
        endcase
    endtask

    task automatic close_writes();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic stim_row_t reg_row(bit [2:0] idx, bit [31:0] value);
        stim_row_t r;
        r = '{ROW_REG, idx, value, CMD_UPDATE, 32'd0, 32'd0, 1'b0, IDLE_WORD};
        return r;
    endfunction

    function automatic stim_row_t word_row(bit cmd, bit [31:0] tus, bit [31:0] tms,
                                           bit typed, motion_word_t want);
        stim_row_t r;
        r = '{ROW_WORD, 3'd0, 32'd0, cmd, tus, tms, typed, want};
        return r;
    endfunction

    task automatic check_field(input string name, input bit [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing pending");
                fail_count++;
            end else begin
                head_word = pending_words.pop_front();
                check_field("step_pulse", 32'(head_word.pulse), 32'(res_ch.step_pulse));
                check_field("driver_enable", 32'(head_word.enable),
                            32'(res_ch.driver_enable));
                check_field("direction_level", 32'(head_word.dir),
                            32'(res_ch.direction_level));
                check_field("phase", 32'(head_word.ph), 32'(res_ch.phase));
                check_field("segment_number", 32'(head_word.seg), 32'(res_ch.segment_number));
                check_field("clockwise_total", head_word.cw, res_ch.clockwise_total);
                check_field("counter_clockwise_total", head_word.ccw,
                            res_ch.counter_clockwise_total);
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                receiver_calm = !receiver_calm;
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                n = pause_length(receiver_calm);
                if (n > 0) begin
                    res_ch.ready = 1'b0;
                    repeat (n - 1) @(negedge clk);
                end else
                    res_ch.ready = 1'b1;
            end
        end
    end

    initial
    begin
        stim_row_t   plan [$];
        bit          in_cfg;
        bit          hold_done;
        bit          running;
        bit          cmd;
        bit [31:0]   tus;
        bit [31:0]   tms;
        bit [31:0]   ms_clock;
        int          rand_base;
        int          move_count;
        int          cap;
        int          tail;
        int          n;
        int          sel;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_UPDATE;
        cmd_ch.time_us = '0;
        cmd_ch.time_ms = '0;

        // after reset nothing moves, whatever the times
        plan.push_back(word_row(CMD_UPDATE, 32'd0, 32'd0, 1'b1, IDLE_WORD));
        plan.push_back(word_row(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, IDLE_WORD));
        // arm with a zero step count is dropped
        plan.push_back(reg_row(REG_STEPS, 32'd0));
        plan.push_back(word_row(CMD_ARM, 32'h0000_1234, 32'd0, 1'b1, IDLE_WORD));
        // one-step move, duration 1, counter-clockwise, keep enabled
        plan.push_back(reg_row(REG_START, 32'd0));
        plan.push_back(reg_row(REG_DIR, 32'd1));
        plan.push_back(reg_row(REG_STEPS, 32'd1));
        plan.push_back(reg_row(REG_DUR, 32'd1));
        plan.push_back(reg_row(REG_KEEP, 32'd1));
        plan.push_back(word_row(CMD_ARM, 32'd0, 32'd0, 1'b1,
                                motion_word_t'{1'b0, 1'b0, 1'b1, PH_SCHED, 4'd0, 32'd0, 32'd0}));
        plan.push_back(word_row(CMD_UPDATE, 32'd0, 32'd0, 1'b1,
                                motion_word_t'{1'b0, 1'b1, 1'b1, PH_ACTIVE, 4'd0, 32'd0, 32'd0}));
        for (int k = 1; k <= 12; k++)
            plan.push_back(word_row(CMD_UPDATE, 32'(k) << 16, 32'(k), 1'b0, IDLE_WORD));
        // widest move, latest start, then re-arm while active
        plan.push_back(reg_row(REG_START, 32'hFFFF_FFFF));
        plan.push_back(reg_row(REG_DIR, 32'd0));
        plan.push_back(reg_row(REG_STEPS, 32'h0000_FFFF));
        plan.push_back(reg_row(REG_DUR, 32'h0000_FFFF));
        plan.push_back(reg_row(REG_KEEP, 32'd0));
        plan.push_back(word_row(CMD_ARM, 32'h0010_0000, 32'd0, 1'b0, IDLE_WORD));
        plan.push_back(word_row(CMD_UPDATE, 32'h0020_0000, 32'hFFFF_FFFE, 1'b0, IDLE_WORD));
        plan.push_back(word_row(CMD_UPDATE, 32'h0030_0000, 32'hFFFF_FFFF, 1'b0, IDLE_WORD));
        for (int k = 4; k <= 6; k++)
            plan.push_back(word_row(CMD_UPDATE, 32'(k) << 20, 32'hFFFF_FFFF, 1'b0, IDLE_WORD));
        plan.push_back(word_row(CMD_ARM, 32'h0070_0000, 32'hFFFF_FFFF, 1'b0, IDLE_WORD));
        plan.push_back(word_row(CMD_UPDATE, 32'hFFFF_FFFF, 32'd0, 1'b0, IDLE_WORD));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        in_cfg = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG) begin
                if (!in_cfg) begin
                    drain_block();
                    in_cfg = 1'b1;
                end
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                if (in_cfg) begin
                    close_writes();
                    in_cfg = 1'b0;
                end
                offer_word(plan[i].cmd, plan[i].tus, plan[i].tms, plan[i].typed, plan[i].want);
            end
        end

        rand_base = words_sent;
        move_count = 0;
        hold_done = 1'b0;
        ms_clock = $urandom;
        while (words_sent - rand_base < RANDOM_WORDS)
        begin
            drain_block();
            if (move_count == 0 || $urandom_range(0, 1) == 1) begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    write_reg(REG_START, $urandom);
                else if (sel == 1)
                    write_reg(REG_START, 32'hFFFF_FFFF);
                else if (sel == 2)
                    write_reg(REG_START, 32'd0);
                else
                    write_reg(REG_START, ms_clock + $urandom_range(0, 4));
            end
            if (move_count == 0 || $urandom_range(0, 1) == 1)
                write_reg(REG_DIR, 32'($urandom_range(0, 1)));
            if (move_count == 0 || $urandom_range(0, 1) == 1) begin
                sel = $urandom_range(0, 99);
                // large counts never finish within a move; they get cut off
                if (sel < 3)
                    write_reg(REG_STEPS, 32'd0);
                else if (sel < 6)
                    write_reg(REG_STEPS, 32'h0000_FFFF);
                else if (sel < 10)
                    write_reg(REG_STEPS, $urandom_range(32'h8000, 32'hFFFE));
                else if (sel < 25)
                    write_reg(REG_STEPS, $urandom_range(41, 400));
                else
                    write_reg(REG_STEPS, $urandom_range(1, 40));
            end
            if (move_count == 0 || $urandom_range(0, 1) == 1) begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    write_reg(REG_DUR, 32'd0);
                else if (sel == 1)
                    write_reg(REG_DUR, 32'd1);
                else if (sel == 2)
                    write_reg(REG_DUR, 32'h0000_FFFF);
                else
                    write_reg(REG_DUR, $urandom_range(1, 65535));
            end
            if (move_count == 0 || $urandom_range(0, 1) == 1)
                write_reg(REG_KEEP, 32'($urandom_range(0, 1)));
            close_writes();
            move_count++;

            if ($urandom_range(0, 9) != 0)
                offer_word(CMD_ARM, $urandom, $urandom, 1'b0, IDLE_WORD);
            if (!hold_done && words_sent - rand_base >= 150) begin
                hold_done = 1'b1;
                hold_request = 1'b1;
            end

            cap = $urandom_range(30, 120);
            tail = $urandom_range(0, 3);
            n = 0;
            running = 1'b1;
            while (running && n < cap)
            begin
                if (phase_q == PH_DONE || phase_q == PH_IDLE) begin
                    if (tail == 0)
                        running = 1'b0;
                    else
                        tail--;
                end
                if (running) begin
                    sel = $urandom_range(0, 99);
                    cmd = CMD_UPDATE;
                    if (sel < 8) begin
                        // noise, and now and then a re-arm in mid move
                        tus = $urandom;
                        tms = $urandom;
                        if (sel < 2)
                            cmd = CMD_ARM;
                    end else begin
                        if (sel < 75 || period_now < 2)
                            tus = last_us + 32'(period_now) + $urandom_range(0, 3);
                        else
                            tus = last_us + $urandom_range(0, 32'(period_now) - 1);
                        if (phase_q == PH_SCHED) begin
                            if (sel % 4 == 0 && start_ms_reg != 0)
                                tms = start_ms_reg - 1;
                            else if (start_ms_reg > 32'hFFFF_FFFB)
                                tms = 32'hFFFF_FFFF;
                            else
                                tms = start_ms_reg + $urandom_range(0, 3);
                            ms_clock = tms;
                        end else begin
                            ms_clock = ms_clock + $urandom_range(0, 2);
                            tms = ms_clock;
                        end
                    end
                    offer_word(cmd, tus, tms, 1'b0, IDLE_WORD);
                    n++;
                end
            end
        end

        drain_block();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[cosine_step_profile_generator.f]
hw/rtl/csp_pkg.sv
hw/rtl/csp_if.sv
hw/rtl/csp_div.sv
hw/rtl/cosine_step_profile_generator.sv
verif/cosine_step_profile_generator_tb.sv
